// File: rtl/bbc_pkg.sv
// bbc_pkg: shared types and constants of the bracket balance checker
// token kind and error codes, stack entry and result records, queue sizes
// no dependencies
package bbc_pkg;

   // stack geometry
   localparam int STACK_DEPTH = 64;
   localparam int ADDR_W      = $clog2(STACK_DEPTH);
   localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);

   // payload widths
   localparam int KIND_W   = 3;
   localparam int LINE_W   = 16;
   localparam int COLUMN_W = 12;
   localparam int ERROR_W  = 2;
   localparam int BRKT_W   = 2;

   // token kind codes
   localparam logic [KIND_W-1:0] KIND_OTHER         = 3'd0;
   localparam logic [KIND_W-1:0] KIND_BRACE_OPEN    = 3'd1;
   localparam logic [KIND_W-1:0] KIND_PAREN_OPEN    = 3'd3;
   localparam logic [KIND_W-1:0] KIND_BRACE_CLOSE   = 3'd4;
   localparam logic [KIND_W-1:0] KIND_PAREN_CLOSE   = 3'd6;
   // distance from a close code to its open code
   localparam logic [KIND_W-1:0] KIND_CLOSE_OFFSET  = 3'd3;

   // error codes
   localparam logic [ERROR_W-1:0] ERR_UNMATCHED = 2'd0;
   localparam logic [ERROR_W-1:0] ERR_UNCLOSED  = 2'd1;
   localparam logic [ERROR_W-1:0] ERR_OVERFLOW  = 2'd2;

   // result queue geometry
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   // one open token held on the stack
   typedef struct packed {
      logic [BRKT_W-1:0]   kind;
      logic [LINE_W-1:0]   line;
      logic [COLUMN_W-1:0] column;
   } stack_entry_type;

   // one error report
   typedef struct packed {
      logic [ERROR_W-1:0]  error_kind;
      logic [LINE_W-1:0]   error_line;
      logic [COLUMN_W-1:0] error_column;
      logic                last_of_run;
   } result_type;

   // results produced by one token, first slot filled first
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } rsp_write_type;

endpackage

// File: rtl/bracket_balance_checker.sv
// bracket_balance_checker: top level of the bracket balance checker
// token decode, stack memory with top register and prefetched next entry
// depends on bbc_pkg and bbc_rsp_fifo
//
// Takes one classified token per req_ready cycle and reports unmatched closes,
// the top unclosed open at end of document, and pushes onto a full stack, each
// as a result transfer on the rsp channel (at most two per token, last_of_run
// marking the final one). The open tokens live in a 64-entry synchronous stack
// memory; the top entry sits in a register and the entry below it is read ahead
// every cycle, so a push or pop needs no interlock. Results go through a
// four-entry queue drained one per rsp_ready cycle; req_ready drops while fewer
// than two queue slots are free, so tokens that raise errors faster than rsp
// drains them stall the input. The stack needs no clearing pass after reset.
module bracket_balance_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [bbc_pkg::KIND_W-1:0]     req_token_kind,
   input  logic [bbc_pkg::LINE_W-1:0]     req_line_number,
   input  logic [bbc_pkg::COLUMN_W-1:0]   req_column_number,
   input  logic                           req_end_of_document,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [bbc_pkg::ERROR_W-1:0]    rsp_error_kind,
   output logic [bbc_pkg::LINE_W-1:0]     rsp_error_line,
   output logic [bbc_pkg::COLUMN_W-1:0]   rsp_error_column,
   output logic                           rsp_last_of_run
);
   import bbc_pkg::*;

   stack_entry_type        stack_mem [STACK_DEPTH];
   logic [COUNT_W-1:0]     count_ff, count_in;
   stack_entry_type        top_ff, top_in;
   stack_entry_type        below_ff;
   logic [ADDR_W-1:0]      rd_addr;

   logic                   accept;
   logic                   is_open, is_close;
   logic                   stack_full, do_push, do_pop;
   logic                   overflow_err, unmatched_err, unclosed_err;
   logic [KIND_W-1:0]      want_kind;
   logic [COUNT_W-1:0]     after_count;
   stack_entry_type        new_entry;
   result_type             token_res, unclosed_res;
   rsp_write_type          wr;
   logic                   space_two;
   result_type             rsp_data;

   assign accept    = req_valid && req_ready;
   assign req_ready = space_two;

   // token decode
   always_comb begin
      is_open    = (req_token_kind >= KIND_BRACE_OPEN) && (req_token_kind <= KIND_PAREN_OPEN);
      is_close   = (req_token_kind >= KIND_BRACE_CLOSE) && (req_token_kind <= KIND_PAREN_CLOSE);
      want_kind  = req_token_kind - KIND_CLOSE_OFFSET;
      new_entry.kind   = req_token_kind[BRKT_W-1:0];
      new_entry.line   = req_line_number;
      new_entry.column = req_column_number;
   end

   // push, pop and error decisions against the current top
   always_comb begin
      stack_full    = (count_ff == COUNT_W'(STACK_DEPTH));
      do_push       = accept && is_open && !stack_full;
      overflow_err  = accept && is_open && stack_full;
      do_pop        = accept && is_close && (count_ff != '0)
                      && (top_ff.kind == want_kind[BRKT_W-1:0]);
      unmatched_err = accept && is_close && !do_pop;

      after_count = count_ff;
      top_in      = top_ff;
      if (do_push) begin
         after_count = count_ff + COUNT_W'(1);
         top_in      = new_entry;
      end else if (do_pop) begin
         after_count = count_ff - COUNT_W'(1);
         top_in      = below_ff;
      end

      unclosed_err = accept && req_end_of_document && (after_count != '0);
      count_in     = (accept && req_end_of_document) ? '0 : after_count;
      // prefetch the entry that will sit below the top next cycle
      rd_addr      = ADDR_W'(count_in - COUNT_W'(2));
   end

   // result records
   always_comb begin
      token_res.error_kind   = overflow_err ? ERR_OVERFLOW : ERR_UNMATCHED;
      token_res.error_line   = req_line_number;
      token_res.error_column = req_column_number;
      token_res.last_of_run  = !unclosed_err;

      unclosed_res.error_kind   = ERR_UNCLOSED;
      unclosed_res.error_line   = top_in.line;
      unclosed_res.error_column = top_in.column;
      unclosed_res.last_of_run  = 1'b1;

      wr.count  = 2'(overflow_err || unmatched_err) + 2'(unclosed_err);
      wr.first  = (overflow_err || unmatched_err) ? token_res : unclosed_res;
      wr.second = unclosed_res;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // top of stack register
   always_ff @(posedge clock) begin
      top_ff <= top_in;
   end

   // stack memory: write on push, registered read of the next-below entry
   always_ff @(posedge clock) begin
      if (do_push) begin
         stack_mem[count_ff[ADDR_W-1:0]] <= new_entry;
      end
      below_ff <= stack_mem[rd_addr];
   end

   bbc_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .wr        (wr),
      .space_two (space_two),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_error_kind   = rsp_data.error_kind;
   assign rsp_error_line   = rsp_data.error_line;
   assign rsp_error_column = rsp_data.error_column;
   assign rsp_last_of_run  = rsp_data.last_of_run;

   // fill count bounded by the stack depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(STACK_DEPTH))
      else $error("stack count beyond depth");

   // end of document empties the stack
   a_eod_clear: assert property (@(posedge clock) disable iff (reset)
      (accept && req_end_of_document) |=> (count_ff == '0))
      else $error("stack not cleared at end of document");

   // a push outside end of document grows the stack by one
   a_push_grow: assert property (@(posedge clock) disable iff (reset)
      (do_push && !req_end_of_document) |=> (count_ff == $past(count_ff) + COUNT_W'(1)))
      else $error("push did not grow stack");

   // push and pop never together
   a_push_pop: assert property (@(posedge clock) disable iff (reset)
      !(do_push && do_pop))
      else $error("push and pop in one cycle");

endmodule

// File: rtl/bbc_rsp_fifo.sv
// bbc_rsp_fifo: small result queue between the stack logic and the rsp port
// takes up to two results per cycle, hands out one per transfer
// depends on bbc_pkg
module bbc_rsp_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  bbc_pkg::rsp_write_type wr,
   output logic                  space_two,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output bbc_pkg::result_type   rsp_data
);
   import bbc_pkg::*;

   result_type              queue_mem [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                    pop;

   // read side
   assign rsp_valid = (cnt_ff != '0);
   assign rsp_data  = queue_mem[rd_ptr_ff];
   assign pop       = rsp_valid && rsp_ready;
   assign space_two = (cnt_ff <= FIFO_CNT_W'(FIFO_DEPTH - 2));

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff + FIFO_PTR_W'(wr.count);
      rd_ptr_in = rd_ptr_ff + FIFO_PTR_W'(pop);
      cnt_in    = cnt_ff + FIFO_CNT_W'(wr.count) - FIFO_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // storage writes, second slot follows the first
   always_ff @(posedge clock) begin
      if (wr.count != 2'd0) begin
         queue_mem[wr_ptr_ff] <= wr.first;
      end
      if (wr.count == 2'd2) begin
         queue_mem[wr_ptr_ff + FIFO_PTR_W'(1)] <= wr.second;
      end
   end

   // never more results than slots
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= FIFO_CNT_W'(FIFO_DEPTH))
      else $error("result queue overfilled");

   // writes only arrive while two slots were free
   a_write_room: assert property (@(posedge clock) disable iff (reset)
      (wr.count != 2'd0) |-> space_two)
      else $error("result write without room");

   // a pop with no write leaves one fewer entry
   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      (pop && wr.count == 2'd0) |=> (cnt_ff == $past(cnt_ff) - FIFO_CNT_W'(1)))
      else $error("result queue count slip on pop");

endmodule

// File: tb/bracket_balance_checker_tb.sv
// bracket_balance_checker_tb: self-checking testbench of the bracket balance checker
// a scoreboard class predicts the error reports; tasks drive token documents
// depends on bbc_pkg and bracket_balance_checker
`timescale 1ns / 1ps

module bracket_balance_checker_tb;

   // token codes as they appear on req_token_kind
   typedef enum logic [bbc_pkg::KIND_W-1:0] {
      TK_OTHER, TK_BRACE_OPEN, TK_BRACKET_OPEN, TK_PAREN_OPEN,
      TK_BRACE_CLOSE, TK_BRACKET_CLOSE, TK_PAREN_CLOSE, TK_RESERVED
   } token_kind_e;

   // receiver stall patterns
   typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_mode_e;

   typedef struct {
      token_kind_e                kind;
      logic [bbc_pkg::LINE_W-1:0]   line;
      logic [bbc_pkg::COLUMN_W-1:0] column;
   } token_type;

   localparam int TOKEN_TARGET = 400;

   // tracks open brackets and the error reports still owed by the block
   class bracket_scoreboard;
      logic [bbc_pkg::BRKT_W-1:0]   open_kind   [bbc_pkg::STACK_DEPTH];
      logic [bbc_pkg::LINE_W-1:0]   open_line   [bbc_pkg::STACK_DEPTH];
      logic [bbc_pkg::COLUMN_W-1:0] open_column [bbc_pkg::STACK_DEPTH];
      int unsigned                  open_count;
      bbc_pkg::result_type          owed_errors[$];
      int unsigned                  failures;

      function void note_token(token_kind_e kind, logic [bbc_pkg::LINE_W-1:0] line,
                               logic [bbc_pkg::COLUMN_W-1:0] column, logic eod);
         bbc_pkg::result_type found[2];
         logic [bbc_pkg::BRKT_W-1:0] wanted;
         int n;
         n = 0;
         // opening token: push, or overflow when full
         if (kind inside {TK_BRACE_OPEN, TK_BRACKET_OPEN, TK_PAREN_OPEN}) begin
            if (open_count >= bbc_pkg::STACK_DEPTH) begin
               found[n] = '{bbc_pkg::ERR_OVERFLOW, line, column, 1'b0};
               n++;
            end else begin
               open_kind[open_count]   = bbc_pkg::BRKT_W'(kind);
               open_line[open_count]   = line;
               open_column[open_count] = column;
               open_count++;
            end
         end
         // closing token: pop on a matching top, else unmatched
         else if (kind inside {TK_BRACE_CLOSE, TK_BRACKET_CLOSE, TK_PAREN_CLOSE}) begin
            wanted = bbc_pkg::BRKT_W'(kind - bbc_pkg::KIND_CLOSE_OFFSET);
            if (open_count > 0 && open_kind[open_count-1] == wanted) begin
               open_count--;
            end else begin
               found[n] = '{bbc_pkg::ERR_UNMATCHED, line, column, 1'b0};
               n++;
            end
         end
         // end of document: report the top as unclosed, then clear
         if (eod) begin
            if (open_count > 0) begin
               found[n] = '{bbc_pkg::ERR_UNCLOSED, open_line[open_count-1],
                            open_column[open_count-1], 1'b0};
               n++;
            end
            open_count = 0;
         end
         for (int i = 0; i < n; i++) begin
            found[i].last_of_run = (i == n - 1);
            owed_errors = {owed_errors, found[i]};
         end
      endfunction

      function void compare_field(string name, logic [31:0] wanted, logic [31:0] got);
         if (wanted !== got) begin
            $error("%s: expected %0d, actual %0d", name, wanted, got);
            failures++;
         end
      endfunction

      function void check_result(bbc_pkg::result_type got);
         bbc_pkg::result_type wanted;
         if (owed_errors.size() == 0) begin
            $error("unexpected result: error_kind %0d, error_line %0d, error_column %0d",
                   got.error_kind, got.error_line, got.error_column);
            failures++;
            return;
         end
         wanted = owed_errors.pop_front();
         compare_field("error_kind", 32'(wanted.error_kind), 32'(got.error_kind));
         compare_field("error_line", 32'(wanted.error_line), 32'(got.error_line));
         compare_field("error_column", 32'(wanted.error_column), 32'(got.error_column));
         compare_field("last_of_run", 32'(wanted.last_of_run), 32'(got.last_of_run));
      endfunction

      function int pending();
         return owed_errors.size();
      endfunction
   endclass

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   logic [bbc_pkg::KIND_W-1:0]      req_token_kind = '0;
   logic [bbc_pkg::LINE_W-1:0]      req_line_number = '0;
   logic [bbc_pkg::COLUMN_W-1:0]    req_column_number = '0;
   logic                            req_end_of_document = 1'b0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   logic [bbc_pkg::ERROR_W-1:0]     rsp_error_kind;
   logic [bbc_pkg::LINE_W-1:0]      rsp_error_line;
   logic [bbc_pkg::COLUMN_W-1:0]    rsp_error_column;
   logic                            rsp_last_of_run;

   bracket_scoreboard sb = new;
   int                burst_left = 0;
   int                counted_tokens = 0;
   rx_mode_e          rx_mode = RX_ALWAYS;
   int                rx_hold = 0;

   bracket_balance_checker uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_token_kind      (req_token_kind),
      .req_line_number     (req_line_number),
      .req_column_number   (req_column_number),
      .req_end_of_document (req_end_of_document),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_error_kind      (rsp_error_kind),
      .rsp_error_line      (rsp_error_line),
      .rsp_error_column    (rsp_error_column),
      .rsp_last_of_run     (rsp_last_of_run)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // monitor both channels at each edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            sb.note_token(token_kind_e'(req_token_kind), req_line_number,
                          req_column_number, req_end_of_document);
         if (rsp_valid && rsp_ready)
            sb.check_result('{rsp_error_kind, rsp_error_line, rsp_error_column,
                              rsp_last_of_run});
      end
   end

   // receiver stalls in a randomly picked pattern, picked anew when rx_hold runs out
   always @(posedge clock) begin
      if (rx_hold == 0) begin
         rx_mode <= rx_mode_e'($urandom_range(0, 3));
         rx_hold <= $urandom_range(20, 80);
      end else begin
         rx_hold <= rx_hold - 1;
      end
      case (rx_mode)
         RX_ALWAYS: rsp_ready <= 1'b1;
         RX_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
         RX_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
         default:   rsp_ready <= ~rsp_ready;
      endcase
   end

   // one token transfer, with bursts and gaps in front of it
   task automatic send_token(token_kind_e kind, logic [bbc_pkg::LINE_W-1:0] line,
                             logic [bbc_pkg::COLUMN_W-1:0] column, logic eod);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      req_valid           <= 1'b1;
      req_token_kind      <= kind;
      req_line_number     <= line;
      req_column_number   <= column;
      req_end_of_document <= eod;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      counted_tokens++;
   endtask

   // hold the sender off until every owed report has come back
   task automatic drain_reports();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   function automatic logic [bbc_pkg::LINE_W-1:0] any_line();
      return bbc_pkg::LINE_W'(($urandom_range(0, 7) == 0)
                              ? {bbc_pkg::LINE_W{$urandom_range(0, 1) == 1}}
                              : $urandom_range(0, 65535));
   endfunction

   function automatic logic [bbc_pkg::COLUMN_W-1:0] any_column();
      return bbc_pkg::COLUMN_W'(($urandom_range(0, 7) == 0)
                                ? {bbc_pkg::COLUMN_W{$urandom_range(0, 1) == 1}}
                                : $urandom_range(0, 4095));
   endfunction

   function automatic token_kind_e any_open();
      return token_kind_e'($urandom_range(TK_BRACE_OPEN, TK_PAREN_OPEN));
   endfunction

   // append one token with a random line and column to the end of a document
   function automatic void add_token(ref token_type doc[$], input token_kind_e kind);
      token_type tok;
      tok = '{kind, any_line(), any_column()};
      doc = {doc, tok};
   endfunction

   // send a document, end of document marked on its last token
   task automatic send_document(token_type doc[$]);
      foreach (doc[i])
         send_token(doc[i].kind, doc[i].line, doc[i].column, i == doc.size() - 1);
   endtask

   // mostly well nested document with the odd stray token
   task automatic random_document();
      token_type doc[$];
      token_kind_e nest[$];
      token_kind_e kind;
      int length, pick;
      length = $urandom_range(1, 24);
      for (int i = 0; i < length; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            kind = token_kind_e'($urandom_range(TK_OTHER, TK_RESERVED));
         end else if (pick < 20) begin
            kind = TK_OTHER;
         end else if (nest.size() > 0 && pick < 60) begin
            kind = token_kind_e'(nest.pop_back() + bbc_pkg::KIND_CLOSE_OFFSET);
         end else begin
            kind = any_open();
            nest = {nest, kind};
         end
         add_token(doc, kind);
      end
      // usually close what is still open
      if ($urandom_range(0, 4) < 3)
         while (nest.size() > 0)
            add_token(doc, token_kind_e'(nest.pop_back() + bbc_pkg::KIND_CLOSE_OFFSET));
      send_document(doc);
   endtask

   // nesting near or past the stack depth
   task automatic deep_document(int levels);
      token_type doc[$];
      token_kind_e nest[$];
      token_kind_e kind;
      int closes;
      for (int i = 0; i < levels; i++) begin
         kind = any_open();
         if (nest.size() < bbc_pkg::STACK_DEPTH)
            nest = {nest, kind};
         add_token(doc, kind);
      end
      closes = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      for (int i = 0; i < closes && nest.size() > 0; i++)
         add_token(doc, token_kind_e'(nest.pop_back() + bbc_pkg::KIND_CLOSE_OFFSET));
      send_document(doc);
   endtask

   // unstructured tokens with random end marks
   task automatic noise_tokens();
      int length;
      length = $urandom_range(1, 8);
      repeat (length)
         send_token(token_kind_e'($urandom_range(TK_OTHER, TK_RESERVED)), any_line(),
                    any_column(), $urandom_range(0, 5) == 0);
   endtask

   initial begin
      int pick, deep_count;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: field extremes, every kind, mismatches, end-of-document cases
      send_token(TK_OTHER,         16'd0,     12'd0,    1'b0);
      send_token(TK_RESERVED,      16'hFFFF,  12'hFFF,  1'b0);
      send_token(TK_BRACE_CLOSE,   16'hFFFF,  12'hFFF,  1'b0); // close on empty stack
      send_token(TK_BRACE_OPEN,    16'd0,     12'd0,    1'b0);
      send_token(TK_BRACKET_OPEN,  16'hFFFF,  12'hFFF,  1'b0);
      send_token(TK_PAREN_OPEN,    16'h5555,  12'hAAA,  1'b0);
      send_token(TK_PAREN_CLOSE,   16'hAAAA,  12'h555,  1'b0);
      send_token(TK_BRACE_CLOSE,   16'd7,     12'd9,    1'b0); // wrong kind on top
      send_token(TK_BRACKET_CLOSE, 16'd8,     12'd1,    1'b0);
      send_token(TK_BRACE_CLOSE,   16'd9,     12'd2,    1'b0);
      send_token(TK_BRACKET_CLOSE, 16'd10,    12'd3,    1'b0);
      send_token(TK_PAREN_CLOSE,   16'd11,    12'd4,    1'b1); // unmatched, empty at end
      send_token(TK_OTHER,         16'd12,    12'd5,    1'b1); // end with empty stack
      send_token(TK_PAREN_OPEN,    16'd13,    12'd6,    1'b0);
      send_token(TK_OTHER,         16'd14,    12'd7,    1'b1); // unclosed paren
      send_token(TK_BRACE_OPEN,    16'd15,    12'd8,    1'b0);
      send_token(TK_BRACKET_OPEN,  16'd16,    12'd9,    1'b0);
      send_token(TK_PAREN_CLOSE,   16'd17,    12'd10,   1'b1); // unmatched then unclosed
      send_token(TK_BRACKET_OPEN,  16'hFFFF,  12'd0,    1'b1); // pushed then unclosed
      send_token(TK_RESERVED,      16'd0,     12'hFFF,  1'b1);
      drain_reports();

      // overflow first, then random documents
      deep_document(bbc_pkg::STACK_DEPTH + 2);
      deep_count = 1;
      while (counted_tokens < TOKEN_TARGET) begin
         pick = $urandom_range(0, 19);
         if (pick == 0 && deep_count < 3) begin
            deep_document($urandom_range(bbc_pkg::STACK_DEPTH - 4, bbc_pkg::STACK_DEPTH + 4));
            deep_count++;
         end else if (pick < 4) begin
            noise_tokens();
         end else begin
            random_document();
         end
         if ($urandom_range(0, 5) == 0)
            drain_reports();
      end

      drain_reports();
      repeat (10) @(posedge clock);
      if (sb.failures == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // watchdog
   initial begin
      #3000000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
